@@ rtl/core/hdc_pkg.sv @@
// ----------------------------------------------------------------------------
// hdc_pkg
// Shared widths, codes and fixed-point constants for the heading controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hdc_pkg;

  localparam int HEADING_FRAC_BITS = 6;
  localparam int GAIN_FRAC_BITS    = 20;
  localparam int RATE_FRAC_BITS    = 4;

  localparam int HEADING_W = 24;
  localparam int TURN_W    = 18;
  localparam int TARGET_W  = 25;
  localparam int ERR_W     = 26;
  localparam int RATE_W    = 16;
  localparam int RATE_MAG_W = 17;
  localparam int GAIN_W    = 20;
  localparam int PROD_W    = ERR_W + GAIN_W;
  localparam int TIMEOUT_W = 16;
  localparam int SETTLE_W  = 8;
  localparam int DRIVE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  localparam int PRODUCT_SHIFT = HEADING_FRAC_BITS + GAIN_FRAC_BITS - 15;

  typedef logic signed [HEADING_W-1:0] heading_t;
  typedef logic signed [RATE_W-1:0]    rate_t;
  typedef logic signed [DRIVE_W-1:0]   drive_t;
  typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]       cfg_data_t;

  // Operation codes.
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_TURN_ANGLE    = 2'd0;
  localparam cfg_idx_t CFG_BASE_GAIN     = 2'd1;
  localparam cfg_idx_t CFG_TIMEOUT_TICKS = 2'd2;
  localparam cfg_idx_t CFG_SETTLE_TICKS  = 2'd3;

  // Schedule phases.
  localparam logic [1:0] PHASE_NONE = 2'd0;
  localparam logic [1:0] PHASE_A    = 2'd1;
  localparam logic [1:0] PHASE_B    = 2'd2;
  localparam logic [1:0] PHASE_FINE = 2'd3;

  // Reset values of the registers.
  localparam logic [GAIN_W-1:0]    BASE_GAIN_RST     = GAIN_W'(5243);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = TIMEOUT_W'(250);
  localparam logic [SETTLE_W-1:0]  SETTLE_TICKS_RST  = SETTLE_W'(20);

  // Scheduled gains, rounded to the gain fraction.
  localparam logic [GAIN_W-1:0] GAIN_MID =
    GAIN_W'(((64'd4 << GAIN_FRAC_BITS) + 64'd500) / 64'd1000);
  localparam logic [GAIN_W-1:0] GAIN_FINE =
    GAIN_W'(((64'd1 << GAIN_FRAC_BITS) + 64'd500) / 64'd1000);

  // Heading error bands, in heading units.
  localparam logic [ERR_W-1:0] ERR_3   = ERR_W'(3   << HEADING_FRAC_BITS);
  localparam logic [ERR_W-1:0] ERR_10  = ERR_W'(10  << HEADING_FRAC_BITS);
  localparam logic [ERR_W-1:0] ERR_20  = ERR_W'(20  << HEADING_FRAC_BITS);
  localparam logic [ERR_W-1:0] ERR_60  = ERR_W'(60  << HEADING_FRAC_BITS);
  localparam logic [ERR_W-1:0] ERR_80  = ERR_W'(80  << HEADING_FRAC_BITS);
  localparam logic [ERR_W-1:0] ERR_100 = ERR_W'(100 << HEADING_FRAC_BITS);
  localparam logic [ERR_W-1:0] ERR_180 = ERR_W'(180 << HEADING_FRAC_BITS);

  // Yaw rate bands, in rate units.
  localparam logic [RATE_MAG_W-1:0] RATE_120 = RATE_MAG_W'(120 << RATE_FRAC_BITS);
  localparam logic [RATE_MAG_W-1:0] RATE_210 = RATE_MAG_W'(210 << RATE_FRAC_BITS);
  localparam logic [RATE_MAG_W-1:0] RATE_220 = RATE_MAG_W'(220 << RATE_FRAC_BITS);

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = DRIVE_W'(32767);
  localparam logic [DRIVE_W-1:0] DRIVE_MIN = DRIVE_W'(6226);

  localparam logic [TIMEOUT_W-1:0] TICK_SAT   = '1;
  localparam logic [SETTLE_W-1:0]  SETTLE_SAT = '1;

endpackage

`default_nettype wire

@@ rtl/core/gain_scheduled_heading_controller_core.sv @@
// ----------------------------------------------------------------------------
// gain_scheduled_heading_controller_core
// Gain-scheduled proportional heading controller with settle and timeout.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one transaction per control event. A start
// transaction captures target = heading + turn_angle and clears the schedule
// phase, settle count and tick count; a tick transaction computes the rotate
// drive from the heading error and yaw rate. Every input transaction yields
// exactly one result transaction (drive, finished, timed_out); a start gives
// a zero drive.
// An accepted transaction is loaded into the input register; when the result
// register can advance, the transaction moves through the gain select, the
// 26x20 multiplier and the clamp into the result register. Throughput is one
// transaction per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its value and the
// input register fills; in_stall rises only once both are occupied.
// Reset (rst_n low, synchronous) empties both stages, clears the controller
// state and loads the register defaults. The cfg port writes one register
// per cycle; the user must use it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gain_scheduled_heading_controller_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire hdc_pkg::cfg_idx_t  cfg_index,
  input  wire hdc_pkg::cfg_data_t cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_operation,
  input  wire hdc_pkg::heading_t  in_heading,
  input  wire hdc_pkg::rate_t     in_yaw_rate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output hdc_pkg::drive_t         out_drive,
  output logic                    out_finished,
  output logic                    out_timed_out
);
  import hdc_pkg::*;

  // Configuration registers.
  logic [TURN_W-1:0]    turn_angle_r;
  logic [GAIN_W-1:0]    base_gain_r;
  logic [TIMEOUT_W-1:0] timeout_ticks_r;
  logic [SETTLE_W-1:0]  settle_ticks_r;

  // Controller state.
  logic signed [TARGET_W-1:0] target_r, target_nxt;
  logic [1:0]                 phase_r, phase_nxt;
  logic [SETTLE_W-1:0]        settle_cnt_r, settle_cnt_nxt;
  logic [TIMEOUT_W-1:0]       tick_cnt_r, tick_cnt_nxt;

  // Input register.
  logic     s1_valid_r;
  logic     s1_op_r;
  heading_t s1_heading_r;
  rate_t    s1_rate_r;

  // Result register.
  logic   out_valid_r;
  drive_t out_drive_r, out_drive_nxt;
  logic   out_fin_r, out_fin_nxt;
  logic   out_tout_r, out_tout_nxt;

  logic out_adv, s1_fire, in_fire;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_fire  = in_valid && !in_stall;

  // Datapath signals.
  logic signed [ERR_W-1:0]  err;
  logic [ERR_W-1:0]         abs_err;
  logic signed [RATE_W:0]   rate_ext;
  logic [RATE_MAG_W-1:0]    abs_rate;
  logic [GAIN_W-1:0]        gain;
  logic [PROD_W-1:0]        prod_mag;
  logic [PROD_W-1:0]        prod_sh;
  logic [DRIVE_W-1:0]       mag_clamped;
  logic                     in_band;
  logic [TIMEOUT_W-1:0]     tick_inc;

  assign err = ERR_W'(target_r) - ERR_W'(s1_heading_r);
  assign abs_err = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
  assign rate_ext = (RATE_W+1)'(s1_rate_r);
  assign abs_rate = rate_ext[RATE_W] ? RATE_MAG_W'(-rate_ext) : RATE_MAG_W'(rate_ext);
  assign in_band = abs_err < ERR_3;

  // Gain schedule, evaluated in priority order; later bands override earlier.
  always_comb begin
    gain      = base_gain_r;
    phase_nxt = phase_r;
    if (!(abs_err < ERR_60 && abs_err > ERR_20 && abs_rate > RATE_210)) begin
      if (abs_err < ERR_180 && abs_err > ERR_100) begin
        gain = GAIN_MID;
      end
      if ((abs_err < ERR_100 && abs_rate > RATE_220) || phase_nxt == PHASE_A) begin
        gain      = GAIN_MID;
        phase_nxt = PHASE_A;
      end
      if ((abs_err < ERR_80 && abs_rate > RATE_120) || phase_nxt == PHASE_B) begin
        gain      = GAIN_MID;
        phase_nxt = PHASE_B;
      end
      if (abs_err < ERR_10) begin
        gain      = GAIN_FINE;
        phase_nxt = PHASE_FINE;
      end
    end
  end

  assign prod_mag = PROD_W'(abs_err) * PROD_W'(gain);
  assign prod_sh  = prod_mag >> PRODUCT_SHIFT;

  always_comb begin
    if (prod_sh > PROD_W'(DRIVE_MAX)) begin
      mag_clamped = DRIVE_MAX;
    end else if (prod_sh < PROD_W'(DRIVE_MIN)) begin
      mag_clamped = DRIVE_MIN;
    end else begin
      mag_clamped = DRIVE_W'(prod_sh);
    end
  end

  assign tick_inc = (tick_cnt_r != TICK_SAT) ? tick_cnt_r + 1'b1 : tick_cnt_r;

  always_comb begin
    target_nxt     = target_r;
    settle_cnt_nxt = settle_cnt_r;
    tick_cnt_nxt   = tick_cnt_r;
    out_drive_nxt  = '0;
    out_fin_nxt    = 1'b0;
    out_tout_nxt   = 1'b0;
    if (s1_op_r == OP_START) begin
      target_nxt     = TARGET_W'(s1_heading_r) + TARGET_W'($signed(turn_angle_r));
      settle_cnt_nxt = '0;
      tick_cnt_nxt   = '0;
    end else begin
      // A positive drive needs a strictly positive product; zero goes negative.
      if (in_band) begin
        out_drive_nxt = '0;
      end else if (!err[ERR_W-1] && err != '0 && gain != '0) begin
        out_drive_nxt = mag_clamped;
      end else begin
        out_drive_nxt = -mag_clamped;
      end
      tick_cnt_nxt = tick_inc;
      if (tick_inc >= timeout_ticks_r) begin
        out_tout_nxt = 1'b1;
        out_fin_nxt  = 1'b1;
      end else begin
        if (in_band) begin
          settle_cnt_nxt = (settle_cnt_r != SETTLE_SAT) ? settle_cnt_r + 1'b1 : settle_cnt_r;
        end else begin
          settle_cnt_nxt = '0;
        end
        out_fin_nxt = settle_cnt_nxt >= settle_ticks_r;
      end
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_angle_r    <= '0;
      base_gain_r     <= BASE_GAIN_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
      settle_ticks_r  <= SETTLE_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TURN_ANGLE:    turn_angle_r    <= cfg_wdata[TURN_W-1:0];
        CFG_BASE_GAIN:     base_gain_r     <= cfg_wdata[GAIN_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_SETTLE_TICKS:  settle_ticks_r  <= cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Controller state and stage valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      phase_r      <= PHASE_NONE;
      settle_cnt_r <= '0;
      tick_cnt_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        target_r     <= target_nxt;
        settle_cnt_r <= settle_cnt_nxt;
        tick_cnt_r   <= tick_cnt_nxt;
        phase_r      <= (s1_op_r == OP_START) ? PHASE_NONE : phase_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= in_operation;
      s1_heading_r <= in_heading;
      s1_rate_r    <= in_yaw_rate;
    end
    if (s1_fire) begin
      out_drive_r <= out_drive_nxt;
      out_fin_r   <= out_fin_nxt;
      out_tout_r  <= out_tout_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_drive     = out_drive_r;
  assign out_finished  = out_fin_r;
  assign out_timed_out = out_tout_r;

  // A timeout always reports the transaction as finished.
  a_tout_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_tout_r |-> out_fin_r)
    else $error("timed_out without finished");

  // The drive is either zero or at least the minimum magnitude.
  a_drive_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_r == '0 || out_drive_r >= $signed(DRIVE_MIN) ||
                     out_drive_r <= -$signed(DRIVE_MIN)))
    else $error("drive inside the forbidden magnitude range");

  // The input side only stalls when the input register is occupied.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  // A processed start clears the tick and settle counts and gives a zero, unfinished result.
  a_start_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_op_r == OP_START |=> tick_cnt_r == '0 && settle_cnt_r == '0 &&
                                      out_drive_r == '0 && !out_fin_r)
    else $error("start did not clear the controller state");

endmodule

`default_nettype wire
